FILE: src/utf8_to_hid_keycode_azerty_core_defines.svh
// ----------------------------------------------------------------------------
// UTF-8 to HID keycode (AZERTY) - assertion macros
// Concurrent assertion helpers used by the core RTL file of this block.
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_HID_KEYCODE_AZERTY_CORE_DEFINES_SVH
`define UTF8_TO_HID_KEYCODE_AZERTY_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// expression must hold at every clock edge out of reset
`define U2HK_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error("u2hk assertion failed");

// consequent must hold in the same cycle as the antecedent
`define U2HK_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("u2hk implication failed");

`else

`define U2HK_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define U2HK_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: src/u2hk_pkg.sv
// ----------------------------------------------------------------------------
// u2hk_pkg
// Types, code point constants and the letter table shared by the UTF-8
// decoder, the AZERTY key mapper and the top level.
// ----------------------------------------------------------------------------
package u2hk_pkg;

    localparam int unsigned CP_W    = 21;
    localparam int unsigned ADV_W   = 3;
    localparam int unsigned USAGE_W = 8;

    // advance codes
    localparam logic [ADV_W-1:0] ADV_NONE = 3'd0;
    localparam logic [ADV_W-1:0] ADV_ONE  = 3'd1;
    localparam logic [ADV_W-1:0] ADV_TWO  = 3'd2;
    localparam logic [ADV_W-1:0] ADV_THR  = 3'd3;
    localparam logic [ADV_W-1:0] ADV_FOUR = 3'd4;

    // scalar value limits
    localparam logic [CP_W-1:0] CP_SUPP_MIN = 21'h010000;
    localparam logic [CP_W-1:0] CP_MAX      = 21'h10FFFF;

    // control and punctuation code points
    localparam logic [CP_W-1:0] CP_BS     = 21'h000008;
    localparam logic [CP_W-1:0] CP_TAB    = 21'h000009;
    localparam logic [CP_W-1:0] CP_LF     = 21'h00000A;
    localparam logic [CP_W-1:0] CP_CR     = 21'h00000D;
    localparam logic [CP_W-1:0] CP_SPACE  = 21'h000020;
    localparam logic [CP_W-1:0] CP_APOS   = 21'h000027;
    localparam logic [CP_W-1:0] CP_COMMA  = 21'h00002C;
    localparam logic [CP_W-1:0] CP_MINUS  = 21'h00002D;
    localparam logic [CP_W-1:0] CP_PERIOD = 21'h00002E;
    localparam logic [CP_W-1:0] CP_ZERO   = 21'h000030;
    localparam logic [CP_W-1:0] CP_ONE    = 21'h000031;
    localparam logic [CP_W-1:0] CP_NINE   = 21'h000039;
    localparam logic [CP_W-1:0] CP_UC_A   = 21'h000041;
    localparam logic [CP_W-1:0] CP_UC_Z   = 21'h00005A;
    localparam logic [CP_W-1:0] CP_LC_A   = 21'h000061;
    localparam logic [CP_W-1:0] CP_LC_Z   = 21'h00007A;
    localparam logic [CP_W-1:0] CP_NBSP   = 21'h0000A0;
    localparam logic [CP_W-1:0] CP_A_GRV  = 21'h0000E0;
    localparam logic [CP_W-1:0] CP_C_CED  = 21'h0000E7;
    localparam logic [CP_W-1:0] CP_E_GRV  = 21'h0000E8;
    localparam logic [CP_W-1:0] CP_E_ACU  = 21'h0000E9;
    localparam logic [CP_W-1:0] CP_U_GRV  = 21'h0000F9;
    localparam logic [CP_W-1:0] CP_LSQUO  = 21'h002018;
    localparam logic [CP_W-1:0] CP_RSQUO  = 21'h002019;

    // HID usages
    localparam logic [USAGE_W-1:0] USE_NONE   = 8'd0;
    localparam logic [USAGE_W-1:0] USE_A      = 8'd4;
    localparam logic [USAGE_W-1:0] USE_Q      = 8'd20;
    localparam logic [USAGE_W-1:0] USE_W      = 8'd26;
    localparam logic [USAGE_W-1:0] USE_Z      = 8'd29;
    localparam logic [USAGE_W-1:0] USE_SEMI   = 8'd51;
    localparam logic [USAGE_W-1:0] USE_1      = 8'd30;
    localparam logic [USAGE_W-1:0] USE_2      = 8'd31;
    localparam logic [USAGE_W-1:0] USE_4      = 8'd33;
    localparam logic [USAGE_W-1:0] USE_6      = 8'd35;
    localparam logic [USAGE_W-1:0] USE_7      = 8'd36;
    localparam logic [USAGE_W-1:0] USE_9      = 8'd38;
    localparam logic [USAGE_W-1:0] USE_0      = 8'd39;
    localparam logic [USAGE_W-1:0] USE_ENTER  = 8'd40;
    localparam logic [USAGE_W-1:0] USE_BKSP   = 8'd42;
    localparam logic [USAGE_W-1:0] USE_TAB    = 8'd43;
    localparam logic [USAGE_W-1:0] USE_SPACE  = 8'd44;
    localparam logic [USAGE_W-1:0] USE_QUOTE  = 8'd52;
    localparam logic [USAGE_W-1:0] USE_PERIOD = 8'd55;
    localparam logic [USAGE_W-1:0] USE_COMMA  = 8'd16;

    // letter index (a = 0) of the keys that move on AZERTY
    localparam logic [4:0] LTR_A = 5'd0;
    localparam logic [4:0] LTR_M = 5'd12;
    localparam logic [4:0] LTR_Q = 5'd16;
    localparam logic [4:0] LTR_W = 5'd22;
    localparam logic [4:0] LTR_Z = 5'd25;

    // decoder result
    typedef struct packed {
        logic             ok;
        logic [ADV_W-1:0] adv;
        logic [CP_W-1:0]  cp;
    } t_dec;

    // key mapper result
    typedef struct packed {
        logic               mapped;
        logic [USAGE_W-1:0] usage;
        logic               shift;
    } t_key;

    // full result item
    typedef struct packed {
        t_dec dec;
        t_key key;
    } t_result;

    // AZERTY usage of a letter, index 0..25 from 'a'
    function automatic logic [USAGE_W-1:0] letter_usage(input logic [4:0] idx);
        logic [USAGE_W-1:0] u;
        unique case (idx)
            LTR_A:   u = USE_Q;
            LTR_Q:   u = USE_A;
            LTR_Z:   u = USE_W;
            LTR_W:   u = USE_Z;
            LTR_M:   u = USE_SEMI;
            default: u = USE_A + {3'b000, idx};
        endcase
        return u;
    endfunction

endpackage

FILE: src/u2hk_decode.sv
// ----------------------------------------------------------------------------
// u2hk_decode
// Decodes one UTF-8 sequence of 1 to 4 bytes from a four-byte window and
// rejects malformed, overlong, surrogate, out-of-range and short sequences.
// ----------------------------------------------------------------------------
module u2hk_decode (
    input  logic [7:0]    i_first_byte,
    input  logic [7:0]    i_second_byte,
    input  logic [7:0]    i_third_byte,
    input  logic [7:0]    i_fourth_byte,
    input  logic [2:0]    i_bytes_available,
    output u2hk_pkg::t_dec o_dec
);

    logic        cont1, cont2, cont3;
    logic        have2, have3, have4;
    logic [10:0] v2;
    logic [15:0] v3;
    logic [20:0] v4;
    logic        ok2, ok3, ok4;

    // continuation bytes are 10xxxxxx
    assign cont1 = (i_second_byte[7:6] == 2'b10);
    assign cont2 = (i_third_byte[7:6]  == 2'b10);
    assign cont3 = (i_fourth_byte[7:6] == 2'b10);

    // counts above four behave as four
    assign have2 = (i_bytes_available >= 3'd2);
    assign have3 = (i_bytes_available >= 3'd3);
    assign have4 = (i_bytes_available >= 3'd4);

    // assembled values per sequence length
    assign v2 = {i_first_byte[4:0], i_second_byte[5:0]};
    assign v3 = {i_first_byte[3:0], i_second_byte[5:0], i_third_byte[5:0]};
    assign v4 = {i_first_byte[2:0], i_second_byte[5:0], i_third_byte[5:0],
                 i_fourth_byte[5:0]};

    // overlong, surrogate and range checks
    assign ok2 = have2 && cont1 && (v2[10:7] != 4'd0);
    assign ok3 = have3 && cont1 && cont2 && (v3[15:11] != 5'd0)
              && (v3[15:11] != 5'b11011);
    assign ok4 = have4 && cont1 && cont2 && cont3
              && (v4 >= u2hk_pkg::CP_SUPP_MIN) && (v4 <= u2hk_pkg::CP_MAX);

    // pick by lead byte class
    always_comb begin
        o_dec.ok  = 1'b0;
        o_dec.adv = u2hk_pkg::ADV_ONE;
        o_dec.cp  = '0;
        if (i_bytes_available == 3'd0) begin
            o_dec.adv = u2hk_pkg::ADV_NONE;
        end else if (i_first_byte[7] == 1'b0) begin
            o_dec.ok  = 1'b1;
            o_dec.cp  = {13'd0, i_first_byte};
        end else if (i_first_byte[7:5] == 3'b110) begin
            if (ok2) begin
                o_dec.ok  = 1'b1;
                o_dec.adv = u2hk_pkg::ADV_TWO;
                o_dec.cp  = {10'd0, v2};
            end
        end else if (i_first_byte[7:4] == 4'b1110) begin
            if (ok3) begin
                o_dec.ok  = 1'b1;
                o_dec.adv = u2hk_pkg::ADV_THR;
                o_dec.cp  = {5'd0, v3};
            end
        end else if (i_first_byte[7:3] == 5'b11110) begin
            if (ok4) begin
                o_dec.ok  = 1'b1;
                o_dec.adv = u2hk_pkg::ADV_FOUR;
                o_dec.cp  = v4;
            end
        end
    end

endmodule

FILE: src/u2hk_keymap.sv
// ----------------------------------------------------------------------------
// u2hk_keymap
// Maps a decoded code point to a HID usage and shift flag on a French
// AZERTY layout. Unmapped or failed decodes give all zeros.
// ----------------------------------------------------------------------------
module u2hk_keymap (
    input  u2hk_pkg::t_dec i_dec,
    output u2hk_pkg::t_key o_key
);

    logic [20:0] cp;
    logic [4:0]  ltr_idx;
    logic [3:0]  dig_idx;

    assign cp      = i_dec.cp;
    // 'a' and 'A' both sit at 1 in the low five bits
    assign ltr_idx = cp[4:0] - 5'd1;
    assign dig_idx = cp[3:0] - 4'd1;

    // lookup: fixed code points first, then letter and digit ranges
    always_comb begin
        o_key.mapped = 1'b1;
        o_key.usage  = u2hk_pkg::USE_NONE;
        o_key.shift  = 1'b0;
        case (cp)
            u2hk_pkg::CP_LF,
            u2hk_pkg::CP_CR:     o_key.usage = u2hk_pkg::USE_ENTER;
            u2hk_pkg::CP_TAB:    o_key.usage = u2hk_pkg::USE_TAB;
            u2hk_pkg::CP_SPACE,
            u2hk_pkg::CP_NBSP:   o_key.usage = u2hk_pkg::USE_SPACE;
            u2hk_pkg::CP_BS:     o_key.usage = u2hk_pkg::USE_BKSP;
            u2hk_pkg::CP_APOS,
            u2hk_pkg::CP_LSQUO,
            u2hk_pkg::CP_RSQUO:  o_key.usage = u2hk_pkg::USE_4;
            u2hk_pkg::CP_COMMA:  o_key.usage = u2hk_pkg::USE_COMMA;
            u2hk_pkg::CP_PERIOD: o_key.usage = u2hk_pkg::USE_PERIOD;
            u2hk_pkg::CP_MINUS:  o_key.usage = u2hk_pkg::USE_6;
            u2hk_pkg::CP_E_ACU:  o_key.usage = u2hk_pkg::USE_2;
            u2hk_pkg::CP_E_GRV:  o_key.usage = u2hk_pkg::USE_7;
            u2hk_pkg::CP_A_GRV:  o_key.usage = u2hk_pkg::USE_0;
            u2hk_pkg::CP_C_CED:  o_key.usage = u2hk_pkg::USE_9;
            u2hk_pkg::CP_U_GRV:  o_key.usage = u2hk_pkg::USE_QUOTE;
            u2hk_pkg::CP_ZERO: begin
                o_key.usage = u2hk_pkg::USE_0;
                o_key.shift = 1'b1;
            end
            default: begin
                if (cp >= u2hk_pkg::CP_LC_A && cp <= u2hk_pkg::CP_LC_Z) begin
                    o_key.usage = u2hk_pkg::letter_usage(ltr_idx);
                end else if (cp >= u2hk_pkg::CP_UC_A && cp <= u2hk_pkg::CP_UC_Z) begin
                    o_key.usage = u2hk_pkg::letter_usage(ltr_idx);
                    o_key.shift = 1'b1;
                end else if (cp >= u2hk_pkg::CP_ONE && cp <= u2hk_pkg::CP_NINE) begin
                    // top row digits need shift on AZERTY
                    o_key.usage = u2hk_pkg::USE_1 + {4'd0, dig_idx};
                    o_key.shift = 1'b1;
                end else begin
                    o_key.mapped = 1'b0;
                end
            end
        endcase
        // nothing maps on a failed decode
        if (!i_dec.ok) begin
            o_key.mapped = 1'b0;
            o_key.usage  = u2hk_pkg::USE_NONE;
            o_key.shift  = 1'b0;
        end
    end

endmodule

FILE: src/utf8_to_hid_keycode_azerty_core.sv
// ----------------------------------------------------------------------------
// utf8_to_hid_keycode_azerty_core
// Decodes one UTF-8 code point from a window of up to four bytes and gives
// its key on a French AZERTY layout. One window is taken every clock cycle;
// each result is offered once the result register is free and can be taken
// at the next clock edge (one input register, one result register, with the
// decoder and key lookup between them). Throughput is set by that single
// register-to-register path, so back-to-back windows stream at one per cycle
// while the output is taken; with both registers full and the output held
// off, the input stalls.
// On a decode failure the advance is one byte and the other result fields are
// zero; with no bytes available the advance is zero.
// ----------------------------------------------------------------------------
`include "utf8_to_hid_keycode_azerty_core_defines.svh"

module utf8_to_hid_keycode_azerty_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_first_byte,
    input  logic [7:0]  i_second_byte,
    input  logic [7:0]  i_third_byte,
    input  logic [7:0]  i_fourth_byte,
    input  logic [2:0]  i_bytes_available,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_decode_ok,
    output logic [2:0]  o_advance,
    output logic [20:0] o_code_point,
    output logic        o_mapped,
    output logic [7:0]  o_usage_code,
    output logic        o_need_shift
);

    logic                  r_in_valid;
    logic                  n_in_valid;
    logic [7:0]            r_b0, r_b1, r_b2, r_b3;
    logic [2:0]            r_avail;
    logic                  r_out_valid;
    logic                  n_out_valid;
    u2hk_pkg::t_result     r_out;
    u2hk_pkg::t_dec        dec;
    u2hk_pkg::t_key        key;
    logic                  out_free;
    logic                  in_take;
    logic                  out_load;

    // pipeline flow control
    assign out_free   = !r_out_valid || i_out_ready;
    assign out_load   = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || out_free;
    assign in_take    = i_in_valid && o_in_ready;

    assign n_in_valid  = in_take ? 1'b1 : (out_load ? 1'b0 : r_in_valid);
    assign n_out_valid = out_load ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_b0    <= i_first_byte;
            r_b1    <= i_second_byte;
            r_b2    <= i_third_byte;
            r_b3    <= i_fourth_byte;
            r_avail <= i_bytes_available;
        end
    end

    // decode and key lookup
    u2hk_decode u_decode (
        .i_first_byte      (r_b0),
        .i_second_byte     (r_b1),
        .i_third_byte      (r_b2),
        .i_fourth_byte     (r_b3),
        .i_bytes_available (r_avail),
        .o_dec             (dec)
    );

    u2hk_keymap u_keymap (
        .i_dec (dec),
        .o_key (key)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.dec <= dec;
            r_out.key <= key;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_decode_ok  = r_out.dec.ok;
    assign o_advance    = r_out.dec.adv;
    assign o_code_point = r_out.dec.cp;
    assign o_mapped     = r_out.key.mapped;
    assign o_usage_code = r_out.key.usage;
    assign o_need_shift = r_out.key.shift;

    // checks
    `U2HK_ASSERT_IMPLIES(a_fail_zero, i_clk, i_rst_n,
        r_out_valid && !r_out.dec.ok,
        r_out.dec.cp == 21'd0 && !r_out.key.mapped && r_out.key.usage == u2hk_pkg::USE_NONE)
    `U2HK_ASSERT_IMPLIES(a_mapped_ok, i_clk, i_rst_n,
        r_out_valid && r_out.key.mapped,
        r_out.dec.ok && r_out.key.usage != u2hk_pkg::USE_NONE)
    `U2HK_ASSERT_IMPLIES(a_ok_adv, i_clk, i_rst_n,
        r_out_valid && r_out.dec.ok,
        r_out.dec.adv != u2hk_pkg::ADV_NONE && r_out.dec.adv <= u2hk_pkg::ADV_FOUR)
    `U2HK_ASSERT_ALWAYS(a_full_stall, i_clk, i_rst_n,
        !(r_in_valid && r_out_valid && !i_out_ready && o_in_ready))

endmodule

FILE: bench/utf8_key_check_pkg.sv
// ----------------------------------------------------------------------------
// utf8_key_check_pkg
// Window type, the expected-key calculation and the scoreboard for the UTF-8
// to AZERTY keycode bench. The calculation decodes one code point from the
// window and looks its key up on the AZERTY layout. The scoreboard keeps the
// expected keys in order and compares the results against them.
// ----------------------------------------------------------------------------
package utf8_key_check_pkg;

    import u2hk_pkg::*;

    // smallest value that the two- and three-byte forms may carry, and the surrogate range
    localparam logic [CP_W-1:0] CP_TWO_MIN   = 21'h000080;
    localparam logic [CP_W-1:0] CP_THREE_MIN = 21'h000800;
    localparam logic [CP_W-1:0] CP_SURR_LO   = 21'h00D800;
    localparam logic [CP_W-1:0] CP_SURR_HI   = 21'h00DFFF;

    // one input transaction; bytes[0] is the lead byte
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      avail;
    } t_window;

    function automatic logic is_cont(input logic [7:0] b);
        return b[7:6] == 2'b10;
    endfunction

    // key of a lower-case letter; a/q and z/w swap places, m sits right of l
    function automatic logic [USAGE_W-1:0] azerty_letter(input logic [7:0] ch);
        case (ch)
            "a":     return USE_Q;
            "q":     return USE_A;
            "z":     return USE_W;
            "w":     return USE_Z;
            "m":     return USE_SEMI;
            default: return USE_A + (ch - "a");
        endcase
    endfunction

    // key and shift for a decoded code point, all zero when there is no key
    function automatic t_key key_for_char(input logic [CP_W-1:0] cp);
        t_key k;
        k        = '0;
        k.mapped = 1'b1;
        case (cp)
            CP_LF, CP_CR:                k.usage = USE_ENTER;
            CP_TAB:                      k.usage = USE_TAB;
            CP_BS:                       k.usage = USE_BKSP;
            CP_SPACE, CP_NBSP:           k.usage = USE_SPACE;
            CP_APOS, CP_LSQUO, CP_RSQUO: k.usage = USE_4;
            CP_COMMA:                    k.usage = USE_COMMA;
            CP_PERIOD:                   k.usage = USE_PERIOD;
            CP_MINUS:                    k.usage = USE_6;
            CP_E_ACU:                    k.usage = USE_2;
            CP_E_GRV:                    k.usage = USE_7;
            CP_A_GRV:                    k.usage = USE_0;
            CP_C_CED:                    k.usage = USE_9;
            CP_U_GRV:                    k.usage = USE_QUOTE;
            default: begin
                if (cp >= CP_LC_A && cp <= CP_LC_Z) begin
                    k.usage = azerty_letter(cp[7:0]);
                end else if (cp >= CP_UC_A && cp <= CP_UC_Z) begin
                    k.usage = azerty_letter(8'(cp - CP_UC_A + CP_LC_A));
                    k.shift = 1'b1;
                end else if (cp >= CP_ONE && cp <= CP_NINE) begin
                    // digits need shift on the top row
                    k.usage = USE_1 + 8'(cp - CP_ONE);
                    k.shift = 1'b1;
                end else if (cp == CP_ZERO) begin
                    k.usage = USE_0;
                    k.shift = 1'b1;
                end else begin
                    k = '0;
                end
            end
        endcase
        return k;
    endfunction

    // expected result of one window
    function automatic t_result predict_keystroke(input t_window w);
        t_result          r;
        logic [2:0]       avail;
        logic [CP_W-1:0]  v;
        logic [ADV_W-1:0] len;
        logic [7:0]       b0, b1, b2, b3;
        r     = '0;
        b0    = w.bytes[0];
        b1    = w.bytes[1];
        b2    = w.bytes[2];
        b3    = w.bytes[3];
        // a count above four still means the whole window
        avail = (w.avail > 3'd4) ? 3'd4 : w.avail;
        if (avail == 3'd0) begin
            return r;
        end
        len = ADV_NONE;
        v   = '0;
        if (!b0[7]) begin
            v   = {13'd0, b0};
            len = ADV_ONE;
        end else if (b0[7:5] == 3'b110) begin
            v = {10'd0, b0[4:0], b1[5:0]};
            if (avail >= 3'd2 && is_cont(b1) && v >= CP_TWO_MIN) begin
                len = ADV_TWO;
            end
        end else if (b0[7:4] == 4'b1110) begin
            v = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
            if (avail >= 3'd3 && is_cont(b1) && is_cont(b2) && v >= CP_THREE_MIN &&
                !(v >= CP_SURR_LO && v <= CP_SURR_HI)) begin
                len = ADV_THR;
            end
        end else if (b0[7:3] == 5'b11110) begin
            v = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
            if (avail >= 3'd4 && is_cont(b1) && is_cont(b2) && is_cont(b3) &&
                v >= CP_SUPP_MIN && v <= CP_MAX) begin
                len = ADV_FOUR;
            end
        end
        // rejected: skip one byte, everything else zero
        if (len == ADV_NONE) begin
            r.dec.adv = ADV_ONE;
            return r;
        end
        r.dec.ok  = 1'b1;
        r.dec.adv = len;
        r.dec.cp  = v;
        r.key     = key_for_char(v);
        return r;
    endfunction

    class keystroke_scoreboard;
        t_result     pending_keys[$];
        int unsigned mismatches;
        int unsigned results_seen;
        int unsigned n_empty;
        int unsigned n_rejected;
        int unsigned n_decoded;
        int unsigned n_on_layout;
        int unsigned n_shifted;

        // accepted input transaction: queue its expected result
        function void note_window(input t_window w);
            t_result r;
            r = predict_keystroke(w);
            pending_keys.push_back(r);
            if (r.dec.adv == ADV_NONE) begin
                n_empty++;
            end else if (!r.dec.ok) begin
                n_rejected++;
            end else begin
                n_decoded++;
            end
            if (r.key.mapped) begin
                n_on_layout++;
            end
            if (r.key.shift) begin
                n_shifted++;
            end
        endfunction

        task report(input string what);
            $display("MISMATCH at %0t: %s", $time, what);
            mismatches++;
        endtask

        task compare_field(input string name, input logic [CP_W-1:0] want,
                           input logic [CP_W-1:0] got);
            if (want !== got) begin
                report($sformatf("%s expected 0x%0h, got 0x%0h", name, want, got));
            end
        endtask

        // accepted result transaction: compare with the oldest expectation
        task check_result(input t_result got);
            t_result want;
            results_seen++;
            if (pending_keys.size() == 0) begin
                report("result with no input transaction pending");
                return;
            end
            want = pending_keys.pop_front();
            compare_field("decode_ok",  CP_W'(want.dec.ok),     CP_W'(got.dec.ok));
            compare_field("advance",    CP_W'(want.dec.adv),    CP_W'(got.dec.adv));
            compare_field("code_point", want.dec.cp,            got.dec.cp);
            compare_field("mapped",     CP_W'(want.key.mapped), CP_W'(got.key.mapped));
            compare_field("usage_code", CP_W'(want.key.usage),  CP_W'(got.key.usage));
            compare_field("need_shift", CP_W'(want.key.shift),  CP_W'(got.key.shift));
        endtask
    endclass

endpackage

FILE: bench/utf8_to_hid_keycode_azerty_core_tb.sv
// ----------------------------------------------------------------------------
// utf8_to_hid_keycode_azerty_core_tb
// Streams byte windows through the decoder with random gaps on both sides.
// A directed set covers the code point range limits, rejected forms and the
// key classes, then random windows follow: half of them well-formed characters,
// plus truncated, corrupted, overlong, surrogate, out-of-range and raw bytes.
// Every result is checked field by field, in order, against the scoreboard.
// ----------------------------------------------------------------------------
module utf8_to_hid_keycode_azerty_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import u2hk_pkg::*;
    import utf8_key_check_pkg::*;

    localparam int unsigned RANDOM_WINDOWS = 500;
    localparam int unsigned IDLE_LIMIT     = 1000;
    localparam int unsigned HOLD_AFTER     = 120;
    localparam int unsigned HOLD_CYCLES    = 80;
    localparam int unsigned DRAIN_CYCLES   = 8;

    logic        i_clk             = 1'b0;
    logic        i_rst_n           = 1'b0;
    logic        i_in_valid        = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_first_byte      = 8'd0;
    logic [7:0]  i_second_byte     = 8'd0;
    logic [7:0]  i_third_byte      = 8'd0;
    logic [7:0]  i_fourth_byte     = 8'd0;
    logic [2:0]  i_bytes_available = 3'd0;
    logic        o_out_valid;
    logic        i_out_ready       = 1'b0;
    logic        o_decode_ok;
    logic [2:0]  o_advance;
    logic [20:0] o_code_point;
    logic        o_mapped;
    logic [7:0]  o_usage_code;
    logic        o_need_shift;

    keystroke_scoreboard key_checker = new();
    bit                  in_burst     = 1'b0;
    bit                  out_burst    = 1'b0;
    int unsigned         windows_sent = 0;
    int unsigned         idle_cycles  = 0;

    always #1 i_clk = ~i_clk;

    utf8_to_hid_keycode_azerty_core i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_first_byte      (i_first_byte),
        .i_second_byte     (i_second_byte),
        .i_third_byte      (i_third_byte),
        .i_fourth_byte     (i_fourth_byte),
        .i_bytes_available (i_bytes_available),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_decode_ok       (o_decode_ok),
        .o_advance         (o_advance),
        .o_code_point      (o_code_point),
        .o_mapped          (o_mapped),
        .o_usage_code      (o_usage_code),
        .o_need_shift      (o_need_shift)
    );

    function automatic t_window mk_window(input logic [7:0] b0, input logic [7:0] b1,
                                          input logic [7:0] b2, input logic [7:0] b3,
                                          input logic [2:0] avail);
        t_window w;
        w.bytes = {b3, b2, b1, b0};
        w.avail = avail;
        return w;
    endfunction

    // UTF-8 bit layout of cp in len bytes; no range check, so overlong and
    // out-of-range forms come out too. Unused bytes stay random.
    function automatic t_window encode_utf8(input logic [CP_W-1:0] cp, input int len);
        t_window w;
        w.bytes = $urandom();
        w.avail = 3'd4;
        case (len)
            1: w.bytes[0] = cp[7:0];
            2: begin
                w.bytes[0] = {3'b110, cp[10:6]};
                w.bytes[1] = {2'b10, cp[5:0]};
            end
            3: begin
                w.bytes[0] = {4'b1110, cp[15:12]};
                w.bytes[1] = {2'b10, cp[11:6]};
                w.bytes[2] = {2'b10, cp[5:0]};
            end
            default: begin
                w.bytes[0] = {5'b11110, cp[20:18]};
                w.bytes[1] = {2'b10, cp[17:12]};
                w.bytes[2] = {2'b10, cp[11:6]};
                w.bytes[3] = {2'b10, cp[5:0]};
            end
        endcase
        return w;
    endfunction

    function automatic t_window random_window();
        t_window         w;
        logic [CP_W-1:0] cp;
        int              len;
        int              pos;
        int              tag;
        // base character: two thirds from the layout, one third any scalar value
        case ($urandom_range(0, 5))
            0: cp = CP_W'(CP_LC_A + $urandom_range(0, 25));
            1: cp = CP_W'(CP_UC_A + $urandom_range(0, 25));
            2: cp = CP_W'(CP_ZERO + $urandom_range(0, 9));
            3: begin
                case ($urandom_range(0, 16))
                    0:       cp = CP_BS;
                    1:       cp = CP_TAB;
                    2:       cp = CP_LF;
                    3:       cp = CP_CR;
                    4:       cp = CP_SPACE;
                    5:       cp = CP_APOS;
                    6:       cp = CP_COMMA;
                    7:       cp = CP_MINUS;
                    8:       cp = CP_PERIOD;
                    9:       cp = CP_NBSP;
                    10:      cp = CP_A_GRV;
                    11:      cp = CP_C_CED;
                    12:      cp = CP_E_GRV;
                    13:      cp = CP_E_ACU;
                    14:      cp = CP_U_GRV;
                    15:      cp = CP_LSQUO;
                    default: cp = CP_RSQUO;
                endcase
            end
            default: begin
                case ($urandom_range(1, 4))
                    1: cp = CP_W'($urandom_range(0, 'h7F));
                    2: cp = CP_W'($urandom_range('h80, 'h7FF));
                    3: begin
                        // skip over the surrogate range
                        cp = CP_W'($urandom_range('h800, 'hF7FF));
                        if (cp >= CP_SURR_LO) begin
                            cp = cp + 21'h000800;
                        end
                    end
                    default: cp = CP_W'($urandom_range('h10000, 'h10FFFF));
                endcase
            end
        endcase
        len = (cp < CP_TWO_MIN) ? 1 : (cp < CP_THREE_MIN) ? 2 : (cp < CP_SUPP_MIN) ? 3 : 4;

        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
                w       = encode_utf8(cp, len);
                w.avail = 3'($urandom_range(len, 7));
            end
            5: begin
                // truncated: fewer bytes than the sequence needs
                if (len < 2) begin
                    len = 2;
                end
                w       = encode_utf8(cp, len);
                w.avail = 3'($urandom_range(1, len - 1));
            end
            6: begin
                // one continuation byte loses its 10 prefix
                if (len < 2) begin
                    len = 2;
                end
                w   = encode_utf8(cp, len);
                pos = $urandom_range(1, len - 1);
                tag = $urandom_range(0, 2);
                w.bytes[pos][7:6] = (tag == 2) ? 2'b11 : 2'(tag);
                w.avail = 3'($urandom_range(len, 7));
            end
            7: begin
                case ($urandom_range(0, 2))
                    0: begin
                        // overlong form
                        len = $urandom_range(2, 4);
                        cp  = CP_W'($urandom_range(0, (len == 2) ? 'h7F :
                                                      (len == 3) ? 'h7FF : 'hFFFF));
                        w   = encode_utf8(cp, len);
                    end
                    1: begin
                        len = 3;
                        w   = encode_utf8(CP_W'(CP_SURR_LO + $urandom_range(0, 'h7FF)), len);
                    end
                    default: begin
                        // beyond the last scalar value
                        len = 4;
                        w   = encode_utf8(CP_W'($urandom_range('h110000, 'h1FFFFF)), len);
                    end
                endcase
                w.avail = 3'($urandom_range(len, 7));
            end
            8: begin
                // lead byte that cannot start a sequence
                w = encode_utf8(cp, len);
                w.bytes[0] = $urandom_range(0, 1) ? 8'($urandom_range('h80, 'hBF))
                                                  : 8'($urandom_range('hF8, 'hFF));
                w.avail = 3'($urandom_range(1, 7));
            end
            default: begin
                w.bytes = $urandom();
                w.avail = 3'($urandom_range(0, 7));
            end
        endcase
        return w;
    endfunction

    // offer one window after a random gap and hold it until accepted
    task automatic send_window(input t_window w);
        int gap;
        gap = in_burst ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_first_byte      <= w.bytes[0];
        i_second_byte     <= w.bytes[1];
        i_third_byte      <= w.bytes[2];
        i_fourth_byte     <= w.bytes[3];
        i_bytes_available <= w.avail;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        key_checker.note_window(w);
        windows_sent++;
        if (windows_sent % 32 == 0) begin
            in_burst = ($urandom_range(0, 2) == 0);
        end
    endtask

    // result side: random stalls, bursts, and one long hold-off
    initial begin
        int      stall;
        t_result got;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (key_checker.results_seen == HOLD_AFTER) begin
                // sender keeps offering, so the block fills and stalls its input
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            stall = out_burst ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            got.dec.ok     = o_decode_ok;
            got.dec.adv    = o_advance;
            got.dec.cp     = o_code_point;
            got.key.mapped = o_mapped;
            got.key.usage  = o_usage_code;
            got.key.shift  = o_need_shift;
            key_checker.check_result(got);
            if (key_checker.results_seen % 32 == 0) begin
                out_burst = ($urandom_range(0, 2) == 0);
            end
        end
    end

    // watchdog: too long without a transaction on either channel
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles == IDLE_LIMIT) begin
                $display("tb: failure");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed windows
        send_window(mk_window(8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd0)); // empty window
        send_window(mk_window(8'h61, 8'hFF, 8'h80, 8'h00, 3'd7)); // 'a', count above four
        send_window(mk_window(8'h51, 8'h00, 8'h00, 8'h00, 3'd1)); // 'Q', shifted swap key
        send_window(mk_window(8'h30, 8'hC3, 8'hA9, 8'h00, 3'd5)); // '0'
        send_window(mk_window(8'h0A, 8'h00, 8'h00, 8'h00, 3'd6)); // line feed
        send_window(mk_window(8'hC3, 8'hA9, 8'h00, 8'h00, 3'd2)); // e acute
        send_window(mk_window(8'hE2, 8'h80, 8'h99, 8'h00, 3'd3)); // right single quote
        send_window(mk_window(8'h00, 8'h00, 8'h00, 8'h00, 3'd4)); // U+0000, no key
        send_window(mk_window(8'h7F, 8'hFF, 8'hFF, 8'hFF, 3'd1)); // last one-byte value
        send_window(mk_window(8'hC2, 8'h80, 8'h00, 8'h00, 3'd2)); // first two-byte value
        send_window(mk_window(8'hDF, 8'hBF, 8'hFF, 8'hFF, 3'd4)); // last two-byte value
        send_window(mk_window(8'hE0, 8'hA0, 8'h80, 8'h00, 3'd3)); // first three-byte value
        send_window(mk_window(8'hEF, 8'hBF, 8'hBF, 8'hFF, 3'd7)); // U+FFFF
        send_window(mk_window(8'hF0, 8'h90, 8'h80, 8'h80, 3'd4)); // U+10000
        send_window(mk_window(8'hF4, 8'h8F, 8'hBF, 8'hBF, 3'd4)); // U+10FFFF
        send_window(mk_window(8'hC0, 8'h80, 8'h00, 8'h00, 3'd2)); // overlong, two bytes
        send_window(mk_window(8'hE0, 8'h9F, 8'hBF, 8'h00, 3'd3)); // overlong, three bytes
        send_window(mk_window(8'hF0, 8'h8F, 8'hBF, 8'hBF, 3'd4)); // overlong, four bytes
        send_window(mk_window(8'hED, 8'hA0, 8'h80, 8'h00, 3'd3)); // first surrogate
        send_window(mk_window(8'hED, 8'hBF, 8'hBF, 8'h00, 3'd3)); // last surrogate
        send_window(mk_window(8'hF4, 8'h90, 8'h80, 8'h80, 3'd4)); // above U+10FFFF
        send_window(mk_window(8'hC3, 8'h41, 8'h00, 8'h00, 3'd2)); // bad continuation
        send_window(mk_window(8'hF0, 8'h90, 8'h80, 8'hC0, 3'd4)); // bad last continuation
        send_window(mk_window(8'h80, 8'h80, 8'h80, 8'h80, 3'd1)); // stray continuation
        send_window(mk_window(8'hF8, 8'h88, 8'h80, 8'h80, 3'd4)); // invalid lead
        send_window(mk_window(8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd4)); // invalid lead, all ones
        send_window(mk_window(8'hE2, 8'h80, 8'h99, 8'h00, 3'd2)); // truncated

        repeat (RANDOM_WINDOWS) send_window(random_window());
        i_in_valid <= 1'b0;

        while (key_checker.pending_keys.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d windows: %0d decoded (%0d with a key, %0d shifted), "
                 , windows_sent, key_checker.n_decoded, key_checker.n_on_layout,
                 key_checker.n_shifted);
        $display("%0d rejected, %0d empty; %0d results checked, %0d mismatches.",
                 key_checker.n_rejected, key_checker.n_empty, key_checker.results_seen,
                 key_checker.mismatches);
        if (key_checker.mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
